>>> rtl/core/imsh_pkg.sv
// Shared codes for the indexed min sequence heap.
// No dependencies.
package imsh_pkg;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_UPDATE = 2'd1;
    localparam logic [1:0] REQ_DELETE = 2'd2;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_IGNORED  = 2'd1;
    localparam logic [1:0] ST_REJECTED = 2'd2;

endpackage

>>> rtl/core/imsh_seq_cmp.sv
// Serial-number compare unit: a is before b when (a - b) has its top bit set.
// No dependencies.
module imsh_seq_cmp #(
    parameter int SEQ_BITS = 32
) (
    input  logic [SEQ_BITS-1:0] a,
    input  logic [SEQ_BITS-1:0] b,
    output logic                is_before
);

    logic [SEQ_BITS-1:0] diff;

    assign diff      = a - b;
    assign is_before = diff[SEQ_BITS-1];

endmodule

>>> rtl/core/imsh_heap_mem.sv
// Heap slot memory: one write port, one registered read port.
// No dependencies.
module imsh_heap_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 36
) (
    input  logic                     clk,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/imsh_pos_map.sv
// Peer position map with per-peer valid bits cleared at reset.
// No dependencies.
module imsh_pos_map #(
    parameter int NUM = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [$clog2(NUM)-1:0] rd_addr,
    output logic [$clog2(NUM)-1:0] rd_pos,
    output logic                   rd_vld,
    input  logic                   wr_en,
    input  logic                   clr_en,
    input  logic [$clog2(NUM)-1:0] wr_addr,
    input  logic [$clog2(NUM)-1:0] wr_pos
);

    logic [$clog2(NUM)-1:0] pos_reg [NUM];
    logic [NUM-1:0]         vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (wr_en)
        begin
            vld_reg[wr_addr] <= 1'b1;
        end
        else if (clr_en)
        begin
            vld_reg[wr_addr] <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            pos_reg[wr_addr] <= wr_pos;
        end
    end

    assign rd_pos = pos_reg[rd_addr];
    assign rd_vld = vld_reg[rd_addr];

endmodule

>>> rtl/core/indexed_min_seq_heap.sv
// Indexed binary min-heap of peers keyed by wrap-around sequence numbers.
// Depends on imsh_pkg, imsh_seq_cmp, imsh_heap_mem, imsh_pos_map.
// One heap read port and one compare set the pace. The next request is accepted in the cycle
// after the result loads. Reset (rst_n, async low) empties the heap.
module indexed_min_seq_heap #(
    parameter int NUM_PEERS = 16,
    parameter int SEQ_BITS  = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [3:0]  peer,
    input  logic [31:0] seq_value,
    input  logic [31:0] discard_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [31:0] result_seq,
    output logic [31:0] min_seq,
    output logic        heap_empty
);

    localparam int IW  = $clog2(NUM_PEERS);      // position / peer index
    localparam int CW  = $clog2(NUM_PEERS + 1);  // element count
    localparam int XW  = IW + 2;                 // child index arithmetic
    localparam int EW  = IW + SEQ_BITS;          // heap entry {peer, seq}

    // Sequencer states, one-hot.
    typedef enum logic [15:0] {
        S_IDLE    = 16'h0001,
        S_CHECK   = 16'h0002,
        S_UPD_CHK = 16'h0004,
        S_DEL_LD  = 16'h0008,
        S_UP_RD   = 16'h0010,
        S_UP_CMP  = 16'h0020,
        S_UP_END  = 16'h0040,
        S_DN_LD   = 16'h0080,
        S_DN_LX   = 16'h0100,
        S_DN_RD   = 16'h0200,
        S_DN_C1   = 16'h0400,
        S_DN_C2   = 16'h0800,
        S_DN_CMP  = 16'h1000,
        S_DN_END  = 16'h2000,
        S_MIN     = 16'h4000,
        S_RES     = 16'h8000
    } state_t;

    state_t state_reg, state_next;

    // Latched transaction.
    logic [1:0]          type_reg;
    logic                pvalid_reg;
    logic [IW-1:0]       peer_reg;
    logic [SEQ_BITS-1:0] val_reg;
    logic [31:0]         disc_reg;

    // Working registers.
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [IW-1:0]       idx_reg, idx_next;
    logic [IW-1:0]       hole_reg, hole_next;
    logic [EW-1:0]       x_reg, x_next;        // element being sifted
    logic [EW-1:0]       cand_reg, cand_next;  // smaller child
    logic [IW-1:0]       cidx_reg, cidx_next;
    logic                del_reg, del_next;
    logic [1:0]          st_reg, st_next;
    logic [31:0]         rseq_reg, rseq_next;

    // Output register.
    logic                out_valid_reg;
    logic [1:0]          status_reg;
    logic [31:0]         result_seq_reg;
    logic [31:0]         min_seq_reg;
    logic                heap_empty_reg;

    // Memory and map ports.
    logic [IW-1:0]       rd_addr;
    logic [EW-1:0]       rd_data;
    logic                wr_en;
    logic [IW-1:0]       wr_addr;
    logic [EW-1:0]       wr_data;
    logic [IW-1:0]       map_pos;
    logic                map_vld;
    logic                map_wr;
    logic                map_clr;
    logic [IW-1:0]       map_addr;

    // Shared compare unit operands.
    logic [SEQ_BITS-1:0] cmp_a, cmp_b;
    logic                cmp_before;

    logic                present;
    logic [XW-1:0]       child;
    logic [XW-1:0]       cnt_x;
    logic [SEQ_BITS-1:0] rd_seq;
    logic [IW-1:0]       rd_peer;
    logic                accept;

    assign rd_seq  = rd_data[SEQ_BITS-1:0];
    assign rd_peer = rd_data[EW-1:SEQ_BITS];
    assign present = pvalid_reg && map_vld;
    assign child   = {1'b0, idx_reg, 1'b1};
    assign cnt_x   = XW'(cnt_reg);
    assign accept  = in_valid && in_ready;

    assign in_ready = (state_reg == S_IDLE);

    imsh_seq_cmp #(.SEQ_BITS(SEQ_BITS)) u_cmp (
        .a         (cmp_a),
        .b         (cmp_b),
        .is_before (cmp_before)
    );

    imsh_heap_mem #(.DEPTH(NUM_PEERS), .WIDTH(EW)) u_mem (
        .clk     (clk),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    imsh_pos_map #(.NUM(NUM_PEERS)) u_map (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (peer_reg),
        .rd_pos  (map_pos),
        .rd_vld  (map_vld),
        .wr_en   (map_wr),
        .clr_en  (map_clr),
        .wr_addr (map_addr),
        .wr_pos  (wr_addr)
    );

    // Compare operand select: one compare per cycle.
    always_comb
    begin
        cmp_a = x_reg[SEQ_BITS-1:0];
        cmp_b = rd_seq;
        unique case (state_reg)
            S_UPD_CHK:
            begin
                cmp_a = rd_seq;
                cmp_b = val_reg;
            end
            S_DN_C2:
            begin
                cmp_a = rd_seq;
                cmp_b = cand_reg[SEQ_BITS-1:0];
            end
            S_DN_CMP:
            begin
                cmp_a = cand_reg[SEQ_BITS-1:0];
                cmp_b = x_reg[SEQ_BITS-1:0];
            end
            default:
            begin
                cmp_a = x_reg[SEQ_BITS-1:0];
                cmp_b = rd_seq;
            end
        endcase
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        hole_next  = hole_reg;
        x_next     = x_reg;
        cand_next  = cand_reg;
        cidx_next  = cidx_reg;
        del_next   = del_reg;
        st_next    = st_reg;
        rseq_next  = rseq_reg;
        rd_addr    = '0;
        wr_en      = 1'b0;
        wr_addr    = idx_reg;
        wr_data    = x_reg;
        map_wr     = 1'b0;
        map_clr    = 1'b0;
        map_addr   = x_reg[EW-1:SEQ_BITS];

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_CHECK;
                end
            end

            S_CHECK:
            begin
                st_next   = imsh_pkg::ST_IGNORED;
                rseq_next = '0;
                del_next  = 1'b0;
                state_next = S_MIN;
                case (type_reg)
                    imsh_pkg::REQ_INSERT:
                    begin
                        if (present)
                        begin
                            st_next = imsh_pkg::ST_REJECTED;
                        end
                        else if (pvalid_reg && cnt_reg != CW'(NUM_PEERS))
                        begin
                            st_next    = imsh_pkg::ST_DONE;
                            x_next     = {peer_reg, val_reg};
                            idx_next   = IW'(cnt_reg);
                            cnt_next   = cnt_reg + 1'b1;
                            state_next = S_UP_RD;
                        end
                    end
                    imsh_pkg::REQ_UPDATE:
                    begin
                        rseq_next = disc_reg;
                        if (present)
                        begin
                            rd_addr    = map_pos;
                            idx_next   = map_pos;
                            state_next = S_UPD_CHK;
                        end
                    end
                    imsh_pkg::REQ_DELETE:
                    begin
                        if (present)
                        begin
                            st_next  = imsh_pkg::ST_DONE;
                            map_clr  = 1'b1;
                            map_addr = peer_reg;
                            cnt_next = cnt_reg - 1'b1;
                            if (CW'(map_pos) != cnt_reg - 1'b1)
                            begin
                                rd_addr    = IW'(cnt_reg - 1'b1);
                                idx_next   = map_pos;
                                hole_next  = map_pos;
                                del_next   = 1'b1;
                                state_next = S_DEL_LD;
                            end
                        end
                    end
                    default:
                    begin
                        state_next = S_MIN;
                    end
                endcase
            end

            S_UPD_CHK:
            begin
                if (cmp_before)
                begin
                    st_next    = imsh_pkg::ST_DONE;
                    x_next     = {peer_reg, val_reg};
                    state_next = S_DN_RD;
                end
                else
                begin
                    state_next = S_MIN;
                end
            end

            S_DEL_LD:
            begin
                x_next     = rd_data;
                state_next = S_UP_RD;
            end

            S_UP_RD:
            begin
                rd_addr = IW'((idx_reg - 1'b1) >> 1);
                if (idx_reg == '0)
                begin
                    state_next = S_UP_END;
                end
                else
                begin
                    state_next = S_UP_CMP;
                end
            end

            S_UP_CMP:
            begin
                if (cmp_before)
                begin
                    // parent moves down into the hole
                    wr_en      = 1'b1;
                    wr_data    = rd_data;
                    map_wr     = 1'b1;
                    map_addr   = rd_peer;
                    idx_next   = IW'((idx_reg - 1'b1) >> 1);
                    state_next = S_UP_RD;
                end
                else
                begin
                    state_next = S_UP_END;
                end
            end

            S_UP_END:
            begin
                wr_en  = 1'b1;
                map_wr = 1'b1;
                if (del_reg)
                begin
                    idx_next   = hole_reg;
                    state_next = S_DN_LD;
                end
                else
                begin
                    state_next = S_MIN;
                end
            end

            S_DN_LD:
            begin
                rd_addr    = hole_reg;
                state_next = S_DN_LX;
            end

            S_DN_LX:
            begin
                x_next     = rd_data;
                state_next = S_DN_RD;
            end

            S_DN_RD:
            begin
                rd_addr   = IW'(child);
                cidx_next = IW'(child);
                if (child >= cnt_x)
                begin
                    state_next = S_DN_END;
                end
                else
                begin
                    state_next = S_DN_C1;
                end
            end

            S_DN_C1:
            begin
                cand_next = rd_data;
                rd_addr   = cidx_reg + 1'b1;
                if (XW'(cidx_reg) + 1'b1 < cnt_x)
                begin
                    state_next = S_DN_C2;
                end
                else
                begin
                    state_next = S_DN_CMP;
                end
            end

            S_DN_C2:
            begin
                if (cmp_before)
                begin
                    cand_next = rd_data;
                    cidx_next = cidx_reg + 1'b1;
                end
                state_next = S_DN_CMP;
            end

            S_DN_CMP:
            begin
                if (cmp_before)
                begin
                    // smaller child moves up into the hole
                    wr_en      = 1'b1;
                    wr_data    = cand_reg;
                    map_wr     = 1'b1;
                    map_addr   = cand_reg[EW-1:SEQ_BITS];
                    idx_next   = cidx_reg;
                    state_next = S_DN_RD;
                end
                else
                begin
                    state_next = S_DN_END;
                end
            end

            S_DN_END:
            begin
                wr_en      = 1'b1;
                map_wr     = 1'b1;
                state_next = S_MIN;
            end

            S_MIN:
            begin
                rd_addr    = '0;
                state_next = S_RES;
            end

            S_RES:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (state_reg == S_RES && (!out_valid_reg || out_ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            type_reg   <= req_type;
            pvalid_reg <= (32'(peer) < NUM_PEERS);
            peer_reg   <= IW'(peer);
            val_reg    <= SEQ_BITS'(seq_value);
            disc_reg   <= discard_value;
        end
        idx_reg  <= idx_next;
        hole_reg <= hole_next;
        x_reg    <= x_next;
        cand_reg <= cand_next;
        cidx_reg <= cidx_next;
        del_reg  <= del_next;
        st_reg   <= st_next;
        rseq_reg <= rseq_next;
        if (state_reg == S_RES && (!out_valid_reg || out_ready))
        begin
            status_reg     <= st_reg;
            heap_empty_reg <= (cnt_reg == '0);
            min_seq_reg    <= (cnt_reg == '0) ? 32'd0 : 32'(rd_seq);
            if (type_reg == imsh_pkg::REQ_UPDATE && st_reg == imsh_pkg::ST_DONE)
            begin
                result_seq_reg <= (cnt_reg == '0) ? 32'd0 : 32'(rd_seq);
            end
            else
            begin
                result_seq_reg <= rseq_reg;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign result_seq = result_seq_reg;
    assign min_seq    = min_seq_reg;
    assign heap_empty = heap_empty_reg;

endmodule

>>> tb/indexed_min_seq_heap_tb.sv
// Self-checking testbench for indexed_min_seq_heap: a directed table, then random requests.
// A built-in heap predictor checks every response. Depends on imsh_pkg and the RTL.
`timescale 1ns / 100ps

module indexed_min_seq_heap_tb;

    localparam int NPEER         = 16;
    localparam int WATCHDOG_MAX  = 20000;
    localparam int RANDOM_ITEMS  = 700;
    localparam logic [1:0] REQ_RESERVED = 2'd3;
    localparam logic [4:0] POS_NONE     = 5'd16;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  req_type = imsh_pkg::REQ_INSERT;
    logic [3:0]  peer = '0;
    logic [31:0] seq_value = '0;
    logic [31:0] discard_value = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  status;
    logic [31:0] result_seq;
    logic [31:0] min_seq;
    logic        heap_empty;

    always #5 clk = ~clk;

    indexed_min_seq_heap uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .req_type(req_type), .peer(peer),
        .seq_value(seq_value), .discard_value(discard_value),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .result_seq(result_seq),
        .min_seq(min_seq), .heap_empty(heap_empty)
    );

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] result_seq;
        logic [31:0] min_seq;
        logic        heap_empty;
    } response_t;

    // predictor state: mirror of the heap
    logic [3:0]  hp_slot [NPEER];
    logic [4:0]  hp_pos  [NPEER];
    logic [31:0] hp_seq  [NPEER];
    int          hp_count;

    response_t pending_rsp[$];
    int        err_count = 0;
    int        idle_in_pct = 35;
    int        idle_out_pct = 60;
    bit        hold_off = 1'b0;
    bit        stim_done = 1'b0;

    // serial arithmetic: a before b when a-b has the top bit set
    function automatic bit seq_lt(logic [31:0] a, logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return d[31];
    endfunction

    function automatic void slot_swap(int a, int b);
        logic [3:0] t;
        t = hp_slot[a];
        hp_slot[a] = hp_slot[b];
        hp_slot[b] = t;
        hp_pos[hp_slot[a]] = 5'(a);
        hp_pos[hp_slot[b]] = 5'(b);
    endfunction

    function automatic void climb(int i);
        int up;
        while (i > 0 && i < hp_count)
        begin
            up = (i - 1) / 2;
            if (!seq_lt(hp_seq[hp_slot[i]], hp_seq[hp_slot[up]]))
                break;
            slot_swap(i, up);
            i = up;
        end
    endfunction

    function automatic void descend(int i);
        int c;
        while (i < hp_count)
        begin
            c = 2 * i + 1;
            if (c >= hp_count)
                break;
            if (c + 1 < hp_count && seq_lt(hp_seq[hp_slot[c+1]], hp_seq[hp_slot[c]]))
                c++;
            if (!seq_lt(hp_seq[hp_slot[c]], hp_seq[hp_slot[i]]))
                break;
            slot_swap(i, c);
            i = c;
        end
    endfunction

    function automatic void heap_clear();
        for (int k = 0; k < NPEER; k++)
        begin
            hp_slot[k] = '0;
            hp_pos[k]  = POS_NONE;
            hp_seq[k]  = '0;
        end
        hp_count = 0;
    endfunction

    function automatic response_t heap_apply(logic [1:0] t, logic [3:0] p,
                                             logic [31:0] v, logic [31:0] dv);
        response_t r;
        bit present;
        int i;
        int last;
        r = '0;
        r.status = imsh_pkg::ST_IGNORED;
        present = hp_pos[p] < hp_count;
        case (t)
            imsh_pkg::REQ_INSERT:
            begin
                if (present)
                    r.status = imsh_pkg::ST_REJECTED;
                else if (hp_count < NPEER)
                begin
                    i = hp_count;
                    hp_seq[p] = v;
                    hp_slot[i] = p;
                    hp_pos[p] = 5'(i);
                    hp_count++;
                    climb(i);
                    r.status = imsh_pkg::ST_DONE;
                end
            end
            imsh_pkg::REQ_UPDATE:
            begin
                r.result_seq = dv;
                if (present && seq_lt(hp_seq[p], v))
                begin
                    hp_seq[p] = v;
                    descend(hp_pos[p]);
                    r.result_seq = hp_seq[hp_slot[0]];
                    r.status = imsh_pkg::ST_DONE;
                end
            end
            imsh_pkg::REQ_DELETE:
            begin
                if (present)
                begin
                    i = hp_pos[p];
                    last = hp_count - 1;
                    hp_pos[p] = POS_NONE;
                    hp_count = last;
                    if (i != last)
                    begin
                        hp_slot[i] = hp_slot[last];
                        hp_pos[hp_slot[i]] = 5'(i);
                        climb(i);
                        descend(i);
                    end
                    r.status = imsh_pkg::ST_DONE;
                end
            end
            default: ;
        endcase
        r.min_seq = hp_count > 0 ? hp_seq[hp_slot[0]] : '0;
        r.heap_empty = hp_count == 0;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("tb: mismatch %s got %h want %h at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    // one transaction into the block; valid stays up until accepted and
    // drops only when the sender idles
    task automatic send_req(logic [1:0] t, logic [3:0] p, logic [31:0] v,
                            logic [31:0] dv);
        while ($urandom_range(99) < idle_in_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        req_type      <= t;
        peer          <= p;
        seq_value     <= v;
        discard_value <= dv;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_rsp.push_back(heap_apply(t, p, v, dv));
    endtask

    // receiver: random stalls plus an optional long hold-off
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= !hold_off && ($urandom_range(99) >= idle_out_pct);
    end

    // response checker
    always @(posedge clk)
    begin
        response_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_rsp.size() == 0)
            begin
                report_mismatch("unexpected response", 32'(status), 32'h0);
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (status != want.status)
                    report_mismatch("status", 32'(status), 32'(want.status));
                if (result_seq != want.result_seq)
                    report_mismatch("result_seq", result_seq, want.result_seq);
                if (min_seq != want.min_seq)
                    report_mismatch("min_seq", min_seq, want.min_seq);
                if (heap_empty != want.heap_empty)
                    report_mismatch("heap_empty", 32'(heap_empty), 32'(want.heap_empty));
            end
        end
    end

    // watchdog: cycles with no transaction on either side
    int quiet_cycles = 0;
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_MAX)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // directed rows; fixed expectations only where obvious
    typedef struct {
        logic [1:0]  t;
        logic [3:0]  p;
        logic [31:0] v;
        logic [31:0] dv;
    } stim_row_t;

    stim_row_t dir_rows[] = '{
        '{imsh_pkg::REQ_DELETE, 4'd0,  32'h0,        32'h0},        // delete on empty
        '{imsh_pkg::REQ_UPDATE, 4'd15, 32'h5,        32'hFFFFFFFF}, // update absent
        '{REQ_RESERVED,         4'd3,  32'h1,        32'h1},        // reserved type
        '{imsh_pkg::REQ_INSERT, 4'd0,  32'h0,        32'h0},
        '{imsh_pkg::REQ_INSERT, 4'd0,  32'h9,        32'h0},        // duplicate insert
        '{imsh_pkg::REQ_INSERT, 4'd15, 32'hFFFFFFFF, 32'h0},        // wraps before 0
        '{imsh_pkg::REQ_INSERT, 4'd7,  32'h7FFFFFFF, 32'h0},
        '{imsh_pkg::REQ_INSERT, 4'd8,  32'h80000000, 32'h0},
        '{imsh_pkg::REQ_UPDATE, 4'd15, 32'hFFFFFFF0, 32'hA5A5A5A5}, // stale update
        '{imsh_pkg::REQ_UPDATE, 4'd15, 32'hFFFFFFFF, 32'h5A5A5A5A}, // equal is stale
        '{imsh_pkg::REQ_UPDATE, 4'd15, 32'h00000010, 32'h0},        // raise across wrap
        '{imsh_pkg::REQ_UPDATE, 4'd0,  32'h40000000, 32'h0},
        '{imsh_pkg::REQ_DELETE, 4'd7,  32'h0,        32'h0},        // delete root
        '{imsh_pkg::REQ_DELETE, 4'd7,  32'h0,        32'h0},        // delete absent
        '{imsh_pkg::REQ_DELETE, 4'd8,  32'h0,        32'h0},        // last entry fills the hole
        '{imsh_pkg::REQ_DELETE, 4'd15, 32'h0,        32'h0},
        '{imsh_pkg::REQ_DELETE, 4'd0,  32'h0,        32'h0}         // back to empty
    };

    task automatic run_random(int n);
        logic [1:0] t;
        int r;
        for (int k = 0; k < n; k++)
        begin
            r = $urandom_range(99);
            // favor inserts while the heap is small so it gets deep
            if (r < (hp_count < 10 ? 50 : 25))
                t = imsh_pkg::REQ_INSERT;
            else if (r < 70)
                t = imsh_pkg::REQ_UPDATE;
            else if (r < 97)
                t = imsh_pkg::REQ_DELETE;
            else
                t = REQ_RESERVED;
            send_req(t, 4'($urandom_range(NPEER - 1)),
                     ($urandom_range(3) == 0) ? $urandom : hp_seq[$urandom_range(15)]
                         + $urandom_range(64) - 16,
                     $urandom);
        end
    endtask

    initial
    begin
        response_t want;
        heap_clear();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table; the first three rows are fixed by inspection
        foreach (dir_rows[k])
        begin
            send_req(dir_rows[k].t, dir_rows[k].p, dir_rows[k].v, dir_rows[k].dv);
            if (k < 3)
            begin
                want = '{imsh_pkg::ST_IGNORED, (k == 1) ? 32'hFFFFFFFF : 32'h0, 32'h0, 1'b1};
                if (pending_rsp[$] != want)
                    report_mismatch("directed row", 32'(k), 32'(k));
            end
        end

        // long receiver hold-off with the sender pushing on
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(posedge clk);
                hold_off = 1'b0;
            end
            run_random(20);
        join

        run_random(RANDOM_ITEMS / 3);
        idle_in_pct = 60;
        idle_out_pct = 35;
        run_random(RANDOM_ITEMS / 3);
        idle_in_pct = 0;
        idle_out_pct = 0;
        run_random(RANDOM_ITEMS / 3);
        in_valid <= 1'b0;

        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);

        if (err_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
